@@ src/ata_pkg.sv @@
// ----------------------------------------------------------------------------
// ata_pkg: shared constants and helpers for the tilt angle pipeline
// Sample format, angle format and CORDIC arctangent table generation.
// ----------------------------------------------------------------------------
`default_nettype none

package ata_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STAGES   = 16;

    localparam int FIELD_W  = 16;                 // port field width
    localparam int ACC_FRAC = 24;                 // angle accumulator fraction bits
    localparam int RAD_W    = 48;                 // (b^2 + c^2) << 16
    localparam int SQRT_STEPS = RAD_W / 2;        // one root bit per stage
    localparam int ROOT_W   = SQRT_STEPS;
    localparam int REM_W    = ROOT_W + 2;
    localparam int CX_W     = ROOT_W + 4;         // CORDIC x/y with growth margin
    localparam int ANG_W    = ACC_FRAC + 9;       // +-~100 degrees plus sign

    localparam longint DEG_PER_RAD_Q24 = 64'sd961263669;
    localparam int     ANGLE_LIM       = 90 << ANGLE_FRAC_BITS;

    typedef logic signed [FIELD_W-1:0] sample_t;
    typedef logic signed [ANG_W-1:0]   angle_acc_t;

    // shift-subtract quotient; elaboration only
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in degrees, 24 fraction bits; elaboration only
    function automatic longint stage_angle(input int i);
        longint acc;
        longint rad32;
        longint term;
        int     n;
        int     e;
        acc = 0;
        if (i == 0) begin
            return 64'sd45 <<< ACC_FRAC;
        end
        for (n = 0; n < 32; n++) begin
            e = (2 * n + 1) * i;
            if (e <= 62) begin
                term = longint'(udiv(64'd1 << (62 - e), 64'(2 * n + 1)));
                acc  = n[0] ? acc - term : acc + term;
            end
        end
        rad32 = (acc + (64'sd1 <<< 29)) >>> 30;
        return (rad32 * DEG_PER_RAD_Q24 + (64'sd1 <<< 31)) >>> 32;
    endfunction

endpackage

`default_nettype wire

@@ src/accel_tilt_angles.sv @@
// ----------------------------------------------------------------------------
// accel_tilt_angles: accelerometer tilt angles
// Passes the three axis samples through as Q8.8 g and gives, per axis,
// atan2(axis, |other two|) in degrees, signed Q7.8, via a pipelined
// integer square root followed by a pipelined CORDIC vectoring stage chain.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------
//  input   | s_x_sample, s_y_sample, s_z_sample     | s_valid / s_ready
//  result  | m_accel_x/y/z, m_pitch/roll/yaw_angle  | m_valid / m_ready
//
// One transaction per cycle while the output is not held; 43 register stages
// (2 square/sum stages, 24 root stages, 16 CORDIC stages, 1 rounding stage).
// The whole pipeline advances together; it holds when the result register
// is full and m_ready is low, so s_ready = !m_valid || m_ready.
// aresetn (synchronous) clears only the stage valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angles
    import ata_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire logic signed [FIELD_W-1:0]  s_x_sample,
    input  wire logic signed [FIELD_W-1:0]  s_y_sample,
    input  wire logic signed [FIELD_W-1:0]  s_z_sample,
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      logic signed [FIELD_W-1:0]  m_accel_x,
    output      logic signed [FIELD_W-1:0]  m_accel_y,
    output      logic signed [FIELD_W-1:0]  m_accel_z,
    output      logic signed [FIELD_W-1:0]  m_pitch_angle,
    output      logic signed [FIELD_W-1:0]  m_roll_angle,
    output      logic signed [FIELD_W-1:0]  m_yaw_angle
);

    localparam int P_RT   = 2;
    localparam int P_CR   = P_RT + SQRT_STEPS;
    localparam int P_OUT  = P_CR + CORDIC_STAGES;
    localparam int N_PIPE = P_OUT + 1;
    localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;

    logic                       en;
    logic [N_PIPE-1:0]          vld_reg;
    sample_t                    s_ext [3];
    logic signed [SAMPLE_WIDTH-1:0] s_low [3];

    sample_t                    smp_reg  [N_PIPE][3];
    logic [2*FIELD_W-2:0]       sq_reg   [3];
    logic [RAD_W-1:0]           rad_reg  [3];
    logic [REM_W-1:0]           rem_reg  [SQRT_STEPS][3];
    logic [ROOT_W-1:0]          root_reg [SQRT_STEPS][3];
    logic [RAD_W-1:0]           rv_reg   [SQRT_STEPS][3];
    logic signed [CX_W-1:0]     cx_reg   [CORDIC_STAGES][3];
    logic signed [CX_W-1:0]     cy_reg   [CORDIC_STAGES][3];
    angle_acc_t                 cz_reg   [CORDIC_STAGES][3];
    sample_t                    ang_reg  [3];

    assign en      = !vld_reg[N_PIPE-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[N_PIPE-1];

    assign s_low[0] = s_x_sample[SAMPLE_WIDTH-1:0];
    assign s_low[1] = s_y_sample[SAMPLE_WIDTH-1:0];
    assign s_low[2] = s_z_sample[SAMPLE_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N_PIPE-2:0], s_valid};
        end
    end

    genvar ch, k;
    generate
        for (ch = 0; ch < 3; ch++) begin : g_chan
            localparam int OB = (ch == 0) ? 1 : 0;
            localparam int OC = (ch == 2) ? 1 : 2;

            angle_acc_t ang_rnd;

            assign s_ext[ch] = FIELD_W'(s_low[ch]);

            always_ff @(posedge aclk) begin
                if (en) begin
                    smp_reg[0][ch] <= s_ext[ch];
                    for (int p = 1; p < N_PIPE; p++) begin
                        smp_reg[p][ch] <= smp_reg[p-1][ch];
                    end
                    sq_reg[ch]  <= (2*FIELD_W-1)'(s_ext[ch] * s_ext[ch]);
                    rad_reg[ch] <= {(2*FIELD_W)'(sq_reg[OB]) + (2*FIELD_W)'(sq_reg[OC]),
                                    16'b0};
                end
            end

            // restoring square root, one result bit per stage
            for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
                logic [REM_W-1:0]  rem_in;
                logic [ROOT_W-1:0] root_in;
                logic [RAD_W-1:0]  v_in;
                logic [REM_W+1:0]  rem2;
                logic [REM_W+1:0]  trial;
                logic              ge;

                if (k == 0) begin : g_first
                    assign rem_in  = '0;
                    assign root_in = '0;
                    assign v_in    = rad_reg[ch];
                end else begin : g_next
                    assign rem_in  = rem_reg[k-1][ch];
                    assign root_in = root_reg[k-1][ch];
                    assign v_in    = rv_reg[k-1][ch];
                end

                assign rem2  = {rem_in, v_in[RAD_W-1 -: 2]};
                assign trial = {2'b00, root_in, 2'b01};
                assign ge    = rem2 >= trial;

                always_ff @(posedge aclk) begin
                    if (en) begin
                        rem_reg[k][ch]  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
                        root_reg[k][ch] <= {root_in[ROOT_W-2:0], ge};
                        rv_reg[k][ch]   <= {v_in[RAD_W-3:0], 2'b00};
                    end
                end
            end

            // CORDIC vectoring, angle accumulated in degrees
            for (k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
                localparam angle_acc_t ANG = ANG_W'(stage_angle(k));
                logic signed [CX_W-1:0] x_in;
                logic signed [CX_W-1:0] y_in;
                angle_acc_t             z_in;
                logic signed [CX_W-1:0] xs;
                logic signed [CX_W-1:0] ys;

                if (k == 0) begin : g_first
                    assign x_in = CX_W'(root_reg[SQRT_STEPS-1][ch]);
                    assign y_in = CX_W'($signed({smp_reg[P_CR-1][ch], 8'b0}));
                    assign z_in = '0;
                end else begin : g_next
                    assign x_in = cx_reg[k-1][ch];
                    assign y_in = cy_reg[k-1][ch];
                    assign z_in = cz_reg[k-1][ch];
                end

                assign xs = x_in >>> k;
                assign ys = y_in >>> k;

                always_ff @(posedge aclk) begin
                    if (en) begin
                        if (y_in > 0) begin
                            cx_reg[k][ch] <= x_in + ys;
                            cy_reg[k][ch] <= y_in - xs;
                            cz_reg[k][ch] <= z_in + ANG;
                        end else if (y_in < 0) begin
                            cx_reg[k][ch] <= x_in - ys;
                            cy_reg[k][ch] <= y_in + xs;
                            cz_reg[k][ch] <= z_in - ANG;
                        end else begin
                            cx_reg[k][ch] <= x_in;
                            cy_reg[k][ch] <= y_in;
                            cz_reg[k][ch] <= z_in;
                        end
                    end
                end
            end

            // round half up, clamp to +-90 degrees
            assign ang_rnd = (cz_reg[CORDIC_STAGES-1][ch] +
                              (ANG_W'(1) <<< (RND_SH - 1))) >>> RND_SH;

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (ang_rnd > ANG_W'(ANGLE_LIM)) begin
                        ang_reg[ch] <= FIELD_W'(ANGLE_LIM);
                    end else if (ang_rnd < -ANG_W'(ANGLE_LIM)) begin
                        ang_reg[ch] <= -FIELD_W'(ANGLE_LIM);
                    end else begin
                        ang_reg[ch] <= FIELD_W'(ang_rnd);
                    end
                end
            end
        end
    endgenerate

    assign m_accel_x     = smp_reg[P_OUT][0];
    assign m_accel_y     = smp_reg[P_OUT][1];
    assign m_accel_z     = smp_reg[P_OUT][2];
    assign m_pitch_angle = ang_reg[0];
    assign m_roll_angle  = ang_reg[1];
    assign m_yaw_angle   = ang_reg[2];

`ifndef SYNTHESIS
    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle <= 16'sd23040 && m_pitch_angle >= -16'sd23040))
        else $error("pitch angle out of range");

    a_zero_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accel_z == 16'sd0) |-> (m_yaw_angle == 16'sd0))
        else $error("zero axis gave nonzero angle");

    a_pitch_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accel_x > 16'sd0) |-> (m_pitch_angle >= 16'sd0))
        else $error("pitch sign disagrees with X");

    a_roll_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accel_y < 16'sd0) |-> (m_roll_angle <= 16'sd0))
        else $error("roll sign disagrees with Y");
`endif

endmodule

`default_nettype wire
